// ===== src/sttu_pkg.sv =====
package sttu_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TIMER_W     = 16;
    localparam int SLOT_W      = 8;
    localparam int PORT_W      = 9;
    localparam int UDP_W       = 16;
    localparam int OPCODE_W    = 2;
    localparam int ACTION_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    typedef logic [TIMER_W-1:0]    timer_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [PORT_W-1:0]     port_t;
    typedef logic [UDP_W-1:0]      udp_t;
    typedef logic [OPCODE_W-1:0]   opcode_bits_t;
    typedef logic [ACTION_W-1:0]   action_bits_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_REPLY = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FORWARD = 3'd0,
        ACT_ROUTED  = 3'd1,
        ACT_UDP     = 3'd2,
        ACT_TIMEOUT = 3'd3,
        ACT_INVALID = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TIMEOUT = 1'd0,
        REG_BCAST_BASE   = 1'd1
    } cfg_reg_t;

    localparam port_t  SHARED_PORT    = 9'd1;
    localparam port_t  PORT_OFFSET    = 9'd2;
    localparam port_t  NO_PORT        = 9'd0;
    localparam udp_t   NO_UDP         = 16'd0;
    localparam timer_t TIMEOUT_RESET  = 16'd30;
    localparam udp_t   UDP_BASE_RESET = 16'd0;
    localparam idx_t   LAST_IDX       = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [SLOT_W:0] DEPTH_EXT = (SLOT_W + 1)'(TABLE_DEPTH);

    // one access per cycle to the timer table, read and write at the same entry
    typedef struct packed {
        logic   wr_en;
        idx_t   addr;
        timer_t wr_data;
    } table_cmd_t;

endpackage

// ===== src/sttu_if.sv =====
interface sttu_req_if;
    import sttu_pkg::*;

    logic         valid;
    logic         ready;
    opcode_bits_t opcode;
    slot_t        slot;

    modport source (output valid, output opcode, output slot, input ready);
    modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface sttu_rsp_if;
    import sttu_pkg::*;

    logic         valid;
    logic         ready;
    action_bits_t action;
    slot_t        result_slot;
    port_t        dest_port;
    udp_t         bcast_port;
    logic         last;

    modport source (output valid, output action, output result_slot, output dest_port,
                    output bcast_port, output last, input ready);
    modport sink   (input valid, input action, input result_slot, input dest_port,
                    input bcast_port, input last, output ready);
endinterface

interface sttu_cfg_if;
    import sttu_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sttu_timer_table.sv =====
module sttu_timer_table (
    input  logic                clk,
    input  logic                rst_n,
    input  sttu_pkg::table_cmd_t cmd,
    output sttu_pkg::timer_t    rd_data
);
    import sttu_pkg::*;

    timer_t timer_reg [TABLE_DEPTH];

    assign rd_data = timer_reg[cmd.addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (cmd.wr_en)
        begin
            timer_reg[cmd.addr] <= cmd.wr_data;
        end
    end

endmodule

// ===== src/session_timeout_table_unit.sv =====
// session timeout table
// req channel: one transfer carries an opcode (open, reply, tick) and a slot index.
// rsp channel: result transfers (action, slot, destination port, broadcast port,
//   last flag); last marks the final result of one request. a tick with no expiry
//   gives none.
// cfg channel: register writes, always ready; write only while the block is idle.
// open and reply go through state S_MSG, which puts their result in the output register
// once it is free; req.ready is low in S_MSG, so no new request is taken until then.
// a tick walks the table one slot per cycle, except while an expiry waits on a stalled
//   output register, through a single shared decrementer; req.ready returns after S_FLUSH.
// one expiry result is held back until the next one is found, so last can be set
// on the final result of a tick when the walk ends.
// when the receiver stalls, the result stays in the output register; a new open or
// reply may be accepted meanwhile but waits for the register to free up.
// reset clears every timer at once (no open sessions), sets the open timeout to 30
// ticks and the broadcast base to 0, and empties the output register.
module session_timeout_table_unit (
    input  logic      clk,
    input  logic      rst_n,
    sttu_req_if.sink  req,
    sttu_rsp_if.source rsp,
    sttu_cfg_if.sink  cfg
);
    import sttu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MSG,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t       state_reg, state_next;
    opcode_bits_t op_reg, op_next;
    slot_t        slot_reg, slot_next;
    idx_t         idx_reg, idx_next;
    logic         pend_valid_reg, pend_valid_next;
    idx_t         pend_idx_reg, pend_idx_next;
    timer_t       timeout_reg, timeout_next;
    udp_t         udp_base_reg, udp_base_next;

    logic         out_valid_reg, out_valid_next;
    action_bits_t out_action_reg, out_action_next;
    slot_t        out_slot_reg, out_slot_next;
    port_t        out_port_reg, out_port_next;
    udp_t         out_udp_reg, out_udp_next;
    logic         out_last_reg, out_last_next;

    table_cmd_t   cmd;
    timer_t       rd_data;
    timer_t       dec;
    logic         out_free;
    logic         slot_ok;
    logic         expire;
    logic         live;

    sttu_timer_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.action      = out_action_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.dest_port   = out_port_reg;
    assign rsp.bcast_port  = out_udp_reg;
    assign rsp.last        = out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign slot_ok  = ({1'b0, slot_reg} < DEPTH_EXT);
    // shared decrementer; an expiring entry of 1 goes to 0 through it as well
    assign dec      = rd_data - timer_t'(1);
    assign live     = (rd_data != '0);
    assign expire   = (rd_data == timer_t'(1));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        timeout_next    = timeout_reg;
        udp_base_next   = udp_base_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_action_next = out_action_reg;
        out_slot_next   = out_slot_reg;
        out_port_next   = out_port_reg;
        out_udp_next    = out_udp_reg;
        out_last_next   = out_last_reg;
        cmd.wr_en       = 1'b0;
        cmd.addr        = (state_reg == S_WALK) ? idx_reg : slot_reg[IDX_W-1:0];
        cmd.wr_data     = dec;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OPEN_TIMEOUT: timeout_next  = cfg.data;
                REG_BCAST_BASE:   udp_base_next = cfg.data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.opcode;
                    slot_next = req.slot;
                    case (req.opcode)
                        OP_OPEN, OP_REPLY: state_next = S_MSG;
                        OP_TICK:
                        begin
                            state_next      = S_WALK;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            S_MSG:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_slot_next   = slot_reg;
                    out_last_next   = 1'b1;
                    out_port_next   = NO_PORT;
                    out_udp_next    = NO_UDP;
                    if (!slot_ok)
                    begin
                        out_action_next = ACT_INVALID;
                    end
                    else if (op_reg == OP_OPEN)
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_data     = timeout_reg;
                        out_action_next = ACT_FORWARD;
                        out_port_next   = SHARED_PORT;
                    end
                    else if (live)
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_data     = '0;
                        out_action_next = ACT_ROUTED;
                        out_port_next   = {1'b0, slot_reg} + PORT_OFFSET;
                    end
                    else
                    begin
                        out_action_next = ACT_UDP;
                        out_udp_next    = udp_base_reg + udp_t'(slot_reg);
                    end
                end
            end

            S_WALK:
            begin
                // an expiry with a result already pending needs the output register
                if (!(expire && pend_valid_reg && !out_free))
                begin
                    cmd.wr_en = live;
                    if (expire)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_action_next = ACT_TIMEOUT;
                            out_slot_next   = SLOT_W'(pend_idx_reg);
                            out_port_next   = PORT_W'(pend_idx_reg) + PORT_OFFSET;
                            out_udp_next    = NO_UDP;
                            out_last_next   = 1'b0;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + idx_t'(1);
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    state_next      = S_IDLE;
                    pend_valid_next = 1'b0;
                    out_valid_next  = 1'b1;
                    out_action_next = ACT_TIMEOUT;
                    out_slot_next   = SLOT_W'(pend_idx_reg);
                    out_port_next   = PORT_W'(pend_idx_reg) + PORT_OFFSET;
                    out_udp_next    = NO_UDP;
                    out_last_next   = 1'b1;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            slot_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            udp_base_reg   <= UDP_BASE_RESET;
            out_valid_reg  <= 1'b0;
            out_action_reg <= ACT_FORWARD;
            out_slot_reg   <= '0;
            out_port_reg   <= NO_PORT;
            out_udp_reg    <= NO_UDP;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            timeout_reg    <= timeout_next;
            udp_base_reg   <= udp_base_next;
            out_valid_reg  <= out_valid_next;
            out_action_reg <= out_action_next;
            out_slot_reg   <= out_slot_next;
            out_port_reg   <= out_port_next;
            out_udp_reg    <= out_udp_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ===== src/sttu_checker.sv =====
module sttu_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input sttu_pkg::opcode_bits_t req_opcode,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input sttu_pkg::action_bits_t rsp_action,
    input sttu_pkg::slot_t        rsp_result_slot,
    input sttu_pkg::port_t        rsp_dest_port,
    input sttu_pkg::udp_t         rsp_bcast_port,
    input logic                   rsp_last
);
    import sttu_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
            && $stable(rsp_result_slot) && $stable(rsp_dest_port)
            && $stable(rsp_bcast_port) && $stable(rsp_last))
    else $error("stalled result changed");

    // open or reply transfer drops req.ready in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode == OP_OPEN || req_opcode == OP_REPLY)
            |=> !req_ready)
    else $error("ready did not drop after a message");

    // forward and invalid results always close their request
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_action == ACT_FORWARD)
            |-> rsp_last && (rsp_dest_port == SHARED_PORT) && (rsp_bcast_port == NO_UDP))
    else $error("bad forward result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_action == ACT_INVALID)
            |-> rsp_last && (rsp_dest_port == NO_PORT) && (rsp_bcast_port == NO_UDP))
    else $error("bad invalid-slot result");

    // routed and timeout results go to the slot's own port
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_action == ACT_ROUTED || rsp_action == ACT_TIMEOUT)
            |-> rsp_dest_port == ({1'b0, rsp_result_slot} + PORT_OFFSET))
    else $error("routed port mismatch");

endmodule

bind session_timeout_table_unit sttu_checker u_sttu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_opcode      (req.opcode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_action      (rsp.action),
    .rsp_result_slot (rsp.result_slot),
    .rsp_dest_port   (rsp.dest_port),
    .rsp_bcast_port  (rsp.bcast_port),
    .rsp_last        (rsp.last)
);
